// ===== rtl/htw_pkg.sv =====
// Shared types, constants and datapath operation codes for the hierarchical timer wheel.
// Used by every module of the block; depends on nothing.
package htw_pkg;

	// Pool and wheel geometry.
	localparam int POOL_SIZE  = 32;
	localparam int NEAR_BITS  = 8;
	localparam int FAR_BITS   = 6;
	localparam int FAR_LEVELS = 4;
	localparam int NEAR_SIZE  = 1 << NEAR_BITS;
	localparam int FAR_SIZE   = 1 << FAR_BITS;
	localparam int NUM_SLOTS  = NEAR_SIZE + FAR_LEVELS * FAR_SIZE;
	localparam int ID_W       = $clog2(POOL_SIZE);
	localparam int LINK_W     = $clog2(POOL_SIZE + 1);
	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam int LVL_W      = (FAR_LEVELS > 1) ? $clog2(FAR_LEVELS) : 1;
	localparam logic [LINK_W-1:0] EMPTY = LINK_W'(POOL_SIZE);

	// Input commands.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [4:0]  timer_id;
		logic [31:0] interval;
		logic        periodic;
	} in_beat_t;

	typedef struct packed {
		logic [4:0]  fired_timer;
		logic [63:0] fired_at;
		logic        last_in_tick;
	} out_beat_t;

	// Operations the controller asks of the datapath, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_SWEEP,
		OP_LOAD,
		OP_UNL_RD,
		OP_UNL_WR,
		OP_ARM,
		OP_PLACE_A,
		OP_PLACE_B,
		OP_TICK_INIT,
		OP_CASC_TAKE,
		OP_TAKE_CLR,
		OP_LVL_INC,
		OP_CASC_RD,
		OP_CASC_GOT,
		OP_NEXT,
		OP_ADVANCE,
		OP_FIRE_RD,
		OP_FIRE_GOT
	} dp_op_t;

	// Status the datapath reports back to the controller.
	typedef struct packed {
		logic cmd_tick;
		logic cmd_start;
		logic cmd_stop;
		logic armed;
		logic near_zero;
		logic cur_empty;
		logic slot_is_base;
		logic lvl_last;
		logic repeats;
		logic out_free;
		logic clr_last;
	} dp_status_t;

endpackage

// ===== rtl/htw_datapath.sv =====
// Datapath of the timer wheel: slot and entry memories, the tick counter, slot choice
// and the output register. Depends on htw_pkg; driven by htw_ctrl operations.
module htw_datapath import htw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_op_t     op,
	input  in_beat_t   in_data,
	input  logic       out_stall,
	output logic       out_valid,
	output out_beat_t  out_data,
	output dp_status_t status
);

	// Memories. Slot lists reset through the sweep; entry stores are written before use.
	logic [LINK_W-1:0] head_mem [NUM_SLOTS];
	logic [LINK_W-1:0] tail_mem [NUM_SLOTS];
	logic [LINK_W-1:0] next_mem [POOL_SIZE];
	logic [LINK_W-1:0] prev_mem [POOL_SIZE];
	logic [SLOT_W-1:0] slot_mem [POOL_SIZE];
	logic [63:0]       exp_mem  [POOL_SIZE];
	logic [31:0]       per_mem  [POOL_SIZE];
	logic              rep_mem  [POOL_SIZE];
	logic [POOL_SIZE-1:0] armed_q;

	// Working registers.
	logic [63:0]       now_q, t_q, exp_q;
	logic [1:0]        cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [31:0]       ival_q;
	logic              per_flag_q;
	logic [SLOT_W-1:0] slot_q, tslot_q, clr_q;
	logic [LINK_W-1:0] cur_q, nx_q;
	logic [LVL_W-1:0]  lvl_q;

	// Registered read data.
	logic [LINK_W-1:0] rd_head_q, rd_tail_q, rd_next_q, rd_prev_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [63:0]       rd_exp_q;
	logic [31:0]       rd_per_q;
	logic              rd_rep_q;

	logic              out_valid_q;
	out_beat_t         out_q;

	// Slot of a far level for a given expiry.
	function automatic logic [SLOT_W-1:0] far_slot(input logic [LVL_W-1:0] lvl,
			input logic [63:0] e);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int l = 0; l < FAR_LEVELS; l++) begin
			if (int'(lvl) == l) begin
				r = SLOT_W'(NEAR_SIZE + l * FAR_SIZE)
					+ SLOT_W'((e >> (NEAR_BITS + l * FAR_BITS)) & 64'(FAR_SIZE - 1));
			end
		end
		return r;
	endfunction

	// Slot choice by distance from the current tick count.
	logic [63:0]       span, e_top;
	logic [SLOT_W-1:0] place_slot;
	always_comb begin
		span  = exp_q - now_q;
		e_top = exp_q;
		if (span[63:32] != '0) begin
			e_top[31:0] = now_q[31:0] + 32'hFFFF_FFFF;
		end
		if (span[63])
			place_slot = SLOT_W'(now_q[NEAR_BITS-1:0]);
		else
			place_slot = far_slot(LVL_W'(FAR_LEVELS - 1), e_top);
		for (int l = FAR_LEVELS - 2; l >= 0; l--) begin
			if ((span >> (NEAR_BITS + (l + 1) * FAR_BITS)) == 64'd0) begin
				place_slot = far_slot(LVL_W'(l), exp_q);
			end
		end
		if ((span >> NEAR_BITS) == 64'd0) begin
			place_slot = SLOT_W'(exp_q[NEAR_BITS-1:0]);
		end
	end

	logic [SLOT_W-1:0] casc_slot, near_slot, base_slot;
	assign casc_slot = far_slot(lvl_q, t_q);
	assign near_slot = SLOT_W'(t_q[NEAR_BITS-1:0]);
	assign base_slot = far_slot(lvl_q, 64'd0);

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Status to the controller.
	always_comb begin
		status.cmd_tick     = (cmd_q == CMD_TICK);
		status.cmd_start    = (cmd_q == CMD_START);
		status.cmd_stop     = (cmd_q == CMD_STOP);
		status.armed        = armed_q[id_q];
		status.near_zero    = (now_q[NEAR_BITS-1:0] == '0);
		status.cur_empty    = (cur_q == EMPTY);
		status.slot_is_base = (tslot_q == base_slot);
		status.lvl_last     = (lvl_q == LVL_W'(FAR_LEVELS - 1));
		status.repeats      = rd_rep_q;
		status.out_free     = out_free;
		status.clr_last     = (clr_q == SLOT_W'(NUM_SLOTS - 1));
	end

	// Slot head and tail memories.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_SWEEP: begin
				head_mem[clr_q] <= EMPTY;
				tail_mem[clr_q] <= EMPTY;
			end
			OP_TAKE_CLR: begin
				head_mem[tslot_q] <= EMPTY;
				tail_mem[tslot_q] <= EMPTY;
			end
			OP_CASC_TAKE: rd_head_q <= head_mem[casc_slot];
			OP_ADVANCE:   rd_head_q <= head_mem[near_slot];
			OP_PLACE_A:   rd_tail_q <= tail_mem[place_slot];
			OP_PLACE_B: begin
				if (rd_tail_q == EMPTY) head_mem[slot_q] <= LINK_W'(id_q);
				tail_mem[slot_q] <= LINK_W'(id_q);
			end
			OP_UNL_WR: begin
				if (rd_prev_q == EMPTY) head_mem[rd_slot_q] <= rd_next_q;
				if (rd_next_q == EMPTY) tail_mem[rd_slot_q] <= rd_prev_q;
			end
			default: ;
		endcase
	end

	// Entry memories.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_UNL_RD: begin
				rd_slot_q <= slot_mem[id_q];
				rd_prev_q <= prev_mem[id_q];
				rd_next_q <= next_mem[id_q];
			end
			OP_UNL_WR: begin
				if (rd_prev_q != EMPTY) next_mem[rd_prev_q[ID_W-1:0]] <= rd_next_q;
				if (rd_next_q != EMPTY) prev_mem[rd_next_q[ID_W-1:0]] <= rd_prev_q;
			end
			OP_ARM: begin
				per_mem[id_q] <= ival_q;
				rep_mem[id_q] <= per_flag_q;
			end
			OP_PLACE_A: begin
				slot_mem[id_q] <= place_slot;
				next_mem[id_q] <= EMPTY;
				exp_mem[id_q]  <= exp_q;
			end
			OP_PLACE_B: begin
				prev_mem[id_q] <= rd_tail_q;
				if (rd_tail_q != EMPTY) next_mem[rd_tail_q[ID_W-1:0]] <= LINK_W'(id_q);
			end
			OP_CASC_RD: begin
				rd_next_q <= next_mem[cur_q[ID_W-1:0]];
				rd_exp_q  <= exp_mem[cur_q[ID_W-1:0]];
			end
			OP_FIRE_RD: begin
				rd_next_q <= next_mem[cur_q[ID_W-1:0]];
				rd_per_q  <= per_mem[cur_q[ID_W-1:0]];
				rd_rep_q  <= rep_mem[cur_q[ID_W-1:0]];
			end
			default: ;
		endcase
	end

	// Working payload registers.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				id_q       <= in_data.timer_id;
				ival_q     <= in_data.interval;
				per_flag_q <= in_data.periodic;
			end
			OP_ARM:       exp_q <= now_q + 64'(ival_q);
			OP_PLACE_A:   slot_q <= place_slot;
			OP_TICK_INIT: t_q <= now_q;
			OP_CASC_TAKE: tslot_q <= casc_slot;
			OP_ADVANCE:   tslot_q <= near_slot;
			OP_TAKE_CLR:  cur_q <= rd_head_q;
			OP_CASC_GOT: begin
				nx_q  <= rd_next_q;
				id_q  <= cur_q[ID_W-1:0];
				exp_q <= rd_exp_q;
			end
			OP_NEXT: cur_q <= nx_q;
			OP_FIRE_GOT: begin
				nx_q  <= rd_next_q;
				id_q  <= cur_q[ID_W-1:0];
				exp_q <= t_q + 64'(rd_per_q);
			end
			default: ;
		endcase
	end

	// Control registers: command, tick count, level, sweep pointer, armed flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_TICK;
			now_q   <= '0;
			lvl_q   <= '0;
			clr_q   <= '0;
			armed_q <= '0;
		end else begin
			unique case (op)
				OP_SWEEP:     clr_q <= clr_q + SLOT_W'(1);
				OP_LOAD:      cmd_q <= in_data.command;
				OP_UNL_WR:    armed_q[id_q] <= 1'b0;
				OP_ARM:       armed_q[id_q] <= 1'b1;
				OP_TICK_INIT: lvl_q <= '0;
				OP_LVL_INC:   lvl_q <= lvl_q + LVL_W'(1);
				OP_ADVANCE:   now_q <= t_q + 64'd1;
				OP_FIRE_GOT: begin
					if (!rd_rep_q) armed_q[cur_q[ID_W-1:0]] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Output register: one fired timer per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_FIRE_GOT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_FIRE_GOT) begin
			out_q.fired_timer  <= cur_q[ID_W-1:0];
			out_q.fired_at     <= t_q;
			out_q.last_in_tick <= (rd_next_q == EMPTY);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/htw_ctrl.sv =====
// Controller of the timer wheel: sequences start, stop, cascade and fire steps.
// Depends on htw_pkg; drives htw_datapath through one operation per cycle.
module htw_ctrl import htw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_op_t     op
);

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_UNL_RD,
		S_UNL_WR,
		S_ARM,
		S_PLACE_A,
		S_PLACE_B,
		S_TICK_INIT,
		S_CASC_TAKE,
		S_CASC_CLR,
		S_CASC_LOOP,
		S_CASC_GOT,
		S_CASC_NEXT,
		S_ADVANCE,
		S_FIRE_CLR,
		S_FIRE_LOOP,
		S_FIRE_GOT,
		S_FIRE_NEXT
	} state_t;

	state_t state_q, ret_q;

	// Operation for the current state.
	always_comb begin
		op = OP_NONE;
		unique case (state_q)
			S_CLEAR:     op = OP_SWEEP;
			S_IDLE:      op = in_valid ? OP_LOAD : OP_NONE;
			S_DISPATCH:  op = OP_NONE;
			S_UNL_RD:    op = OP_UNL_RD;
			S_UNL_WR:    op = OP_UNL_WR;
			S_ARM:       op = OP_ARM;
			S_PLACE_A:   op = OP_PLACE_A;
			S_PLACE_B:   op = OP_PLACE_B;
			S_TICK_INIT: op = OP_TICK_INIT;
			S_CASC_TAKE: op = OP_CASC_TAKE;
			S_CASC_CLR:  op = OP_TAKE_CLR;
			S_CASC_LOOP: begin
				if (!status.cur_empty)
					op = OP_CASC_RD;
				else if (status.slot_is_base && !status.lvl_last)
					op = OP_LVL_INC;
			end
			S_CASC_GOT:  op = OP_CASC_GOT;
			S_CASC_NEXT: op = OP_NEXT;
			S_ADVANCE:   op = OP_ADVANCE;
			S_FIRE_CLR:  op = OP_TAKE_CLR;
			S_FIRE_LOOP: op = status.cur_empty ? OP_NONE : OP_FIRE_RD;
			S_FIRE_GOT:  op = status.out_free ? OP_FIRE_GOT : OP_NONE;
			S_FIRE_NEXT: op = OP_NEXT;
			default:     op = OP_NONE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	// State register and return point for the shared placement steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q   <= S_IDLE;
		end else begin
			unique case (state_q)
				S_CLEAR:    if (status.clr_last) state_q <= S_IDLE;
				S_IDLE:     if (in_valid) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					if (status.cmd_tick)
						state_q <= S_TICK_INIT;
					else if ((status.cmd_start || status.cmd_stop) && status.armed)
						state_q <= S_UNL_RD;
					else if (status.cmd_start)
						state_q <= S_ARM;
					else
						state_q <= S_IDLE;
				end
				S_UNL_RD:   state_q <= S_UNL_WR;
				S_UNL_WR:   state_q <= status.cmd_start ? S_ARM : S_IDLE;
				S_ARM: begin
					ret_q   <= S_IDLE;
					state_q <= S_PLACE_A;
				end
				S_PLACE_A:  state_q <= S_PLACE_B;
				S_PLACE_B:  state_q <= ret_q;
				S_TICK_INIT: state_q <= status.near_zero ? S_CASC_TAKE : S_ADVANCE;
				S_CASC_TAKE: state_q <= S_CASC_CLR;
				S_CASC_CLR:  state_q <= S_CASC_LOOP;
				S_CASC_LOOP: begin
					if (!status.cur_empty)
						state_q <= S_CASC_GOT;
					else if (status.slot_is_base && !status.lvl_last)
						state_q <= S_CASC_TAKE;
					else
						state_q <= S_ADVANCE;
				end
				S_CASC_GOT: begin
					ret_q   <= S_CASC_NEXT;
					state_q <= S_PLACE_A;
				end
				S_CASC_NEXT: state_q <= S_CASC_LOOP;
				S_ADVANCE:   state_q <= S_FIRE_CLR;
				S_FIRE_CLR:  state_q <= S_FIRE_LOOP;
				S_FIRE_LOOP: state_q <= status.cur_empty ? S_IDLE : S_FIRE_GOT;
				S_FIRE_GOT: begin
					if (status.out_free) begin
						ret_q   <= S_FIRE_NEXT;
						state_q <= status.repeats ? S_PLACE_A : S_FIRE_NEXT;
					end
				end
				S_FIRE_NEXT: state_q <= S_FIRE_LOOP;
				default:     state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/hierarchical_timer_wheel_top.sv =====
// Top level of the hierarchical timer wheel: controller and datapath joined.
// Depends on htw_pkg, htw_ctrl and htw_datapath.
//
//   channel | direction | handshake            | beat
//   in      | to block  | in_valid / in_stall  | in_beat_t: command, timer_id, interval, periodic
//   out     | from block| out_valid / out_stall| out_beat_t: fired_timer, fired_at, last_in_tick
//
// Start unlinks the timer first if it was armed, then arms and places it; stop unlinks an armed timer.
// A tick fires the timers of the current near slot, re-arming the periodic ones,
// and, when the low eight count bits are zero, first moves timers down from the far levels;
// the walk over the slot lists takes one entry step per memory read.
// After reset a clearing pass over all 512 slots empties the slot lists before the first beat.
// A stalled output holds the walk at the next fired timer; no input is taken until done.
module hierarchical_timer_wheel_top import htw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	dp_op_t     op;
	dp_status_t status;

	htw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.op       (op)
	);

	htw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.status    (status)
	);

endmodule

// ===== rtl/htw_checker.sv =====
// Port-level checks for the hierarchical timer wheel, bound to the top level.
// Depends on htw_pkg.
module htw_checker import htw_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_beat_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_beat_t out_data
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// The block is busy in the cycle after it takes a beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// While a result that is not the last of its tick waits, the tick is still in work.
	a_tick_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_in_tick |-> in_stall)
		else $error("block idle in the middle of a tick");

	// A start or stop taken while no result waits does not bring up a result.
	a_no_result_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.command != CMD_TICK && !out_valid
		|=> ##1 !out_valid)
		else $error("result after start or stop");

endmodule

bind hierarchical_timer_wheel_top htw_checker u_htw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the hierarchical timer wheel top level.
// Depends on htw_pkg and hierarchical_timer_wheel_top; holds its own wheel predictor.
`timescale 1ns / 1ps

module testbench;
	import htw_pkg::*;

	localparam int NIL       = POOL_SIZE;
	localparam int MAX_CYC   = 2000000;
	localparam int N_RANDOM  = 295;
	localparam int HOLD_LEN  = 400;
	localparam logic [63:0] TOP_DIST = 64'h0000_0000_ffff_ffff;
	localparam logic [1:0]  CMD_BAD  = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;

	hierarchical_timer_wheel_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #2 clk = ~clk;

	// Predicted wheel state.
	logic [63:0] wheel_now;
	logic [63:0] tmr_expiry [POOL_SIZE];
	logic [31:0] tmr_period [POOL_SIZE];
	bit          tmr_repeats [POOL_SIZE];
	bit          tmr_armed [POOL_SIZE];
	int          tmr_slot [POOL_SIZE];
	int          tmr_next [POOL_SIZE];
	int          tmr_prev [POOL_SIZE];
	int          slot_first [NUM_SLOTS];
	int          slot_last [NUM_SLOTS];

	out_beat_t fired_q [$];
	int        errors = 0;
	bit        hold_req = 0;

	function automatic int far_index(int lvl, logic [63:0] e);
		return NEAR_SIZE + lvl * FAR_SIZE
			+ int'((e >> (NEAR_BITS + lvl * FAR_BITS)) & (FAR_SIZE - 1));
	endfunction

	function automatic int slot_for(logic [63:0] e);
		logic [63:0] span;
		span = e - wheel_now;
		if (span < NEAR_SIZE)
			return int'(e & (NEAR_SIZE - 1));
		for (int lvl = 0; lvl + 1 < FAR_LEVELS; lvl++) begin
			if (span < (64'd1 << (NEAR_BITS + (lvl + 1) * FAR_BITS)))
				return far_index(lvl, e);
		end
		// Overdue timers go to the current near slot.
		if (span[63])
			return int'(wheel_now & (NEAR_SIZE - 1));
		if (span > TOP_DIST)
			e = wheel_now + TOP_DIST;
		return far_index(FAR_LEVELS - 1, e);
	endfunction

	function automatic void link_timer(int id);
		int s;
		s = slot_for(tmr_expiry[id]);
		tmr_slot[id] = s;
		tmr_next[id] = NIL;
		tmr_prev[id] = slot_last[s];
		if (slot_last[s] == NIL)
			slot_first[s] = id;
		else
			tmr_next[slot_last[s]] = id;
		slot_last[s] = id;
	endfunction

	function automatic void unlink_timer(int id);
		int s, p, n;
		s = tmr_slot[id];
		p = tmr_prev[id];
		n = tmr_next[id];
		if (p == NIL) slot_first[s] = n; else tmr_next[p] = n;
		if (n == NIL) slot_last[s] = p; else tmr_prev[n] = p;
	endfunction

	function automatic int detach_slot(int s);
		int h;
		h = slot_first[s];
		slot_first[s] = NIL;
		slot_last[s] = NIL;
		return h;
	endfunction

	function automatic void wheel_clear();
		wheel_now = '0;
		foreach (tmr_armed[i]) tmr_armed[i] = 0;
		foreach (slot_first[i]) begin
			slot_first[i] = NIL;
			slot_last[i] = NIL;
		end
	endfunction

	// Applies one accepted beat to the predicted wheel and queues the timers it fires.
	function automatic int wheel_apply(in_beat_t b);
		int id, cur, nx, fired, lvl, s, near_slot;
		logic [63:0] t;
		out_beat_t r;
		id = int'(b.timer_id);
		fired = 0;
		if (b.command == CMD_START || b.command == CMD_STOP) begin
			if (tmr_armed[id]) begin
				unlink_timer(id);
				tmr_armed[id] = 0;
			end
			if (b.command == CMD_START) begin
				tmr_period[id] = b.interval;
				tmr_repeats[id] = b.periodic;
				tmr_expiry[id] = wheel_now + b.interval;
				tmr_armed[id] = 1;
				link_timer(id);
			end
		end else if (b.command == CMD_TICK) begin
			t = wheel_now;
			near_slot = int'(t & (NEAR_SIZE - 1));
			// Cascade far slots down when the low bits wrap.
			if (near_slot == 0) begin
				for (lvl = 0; lvl < FAR_LEVELS; lvl++) begin
					s = far_index(lvl, t);
					cur = detach_slot(s);
					while (cur != NIL) begin
						nx = tmr_next[cur];
						link_timer(cur);
						cur = nx;
					end
					if (s != NEAR_SIZE + lvl * FAR_SIZE) break;
				end
			end
			wheel_now = t + 1;
			cur = detach_slot(near_slot);
			while (cur != NIL) begin
				nx = tmr_next[cur];
				if (tmr_repeats[cur]) begin
					tmr_expiry[cur] = t + tmr_period[cur];
					link_timer(cur);
				end else begin
					tmr_armed[cur] = 0;
				end
				r.fired_timer = cur[4:0];
				r.fired_at = t;
				r.last_in_tick = 1'b0;
				fired_q = {fired_q, r};
				fired++;
				cur = nx;
			end
			if (fired > 0) begin
				r = fired_q.pop_back();
				r.last_in_tick = 1'b1;
				fired_q = {fired_q, r};
			end
		end
		return fired;
	endfunction

	// Directed rows; pinned rows carry the single timer that must fire.
	typedef struct {
		in_beat_t  beat;
		bit        pinned;
		out_beat_t want;
	} row_t;

	function automatic row_t mk(logic [1:0] c, int id, logic [31:0] iv, bit per,
			bit pin = 0, int fid = 0, logic [63:0] fat = 0);
		row_t r;
		r.beat = '{command: c, timer_id: id[4:0], interval: iv, periodic: per};
		r.pinned = pin;
		r.want = '{fired_timer: fid[4:0], fired_at: fat, last_in_tick: 1'b1};
		return r;
	endfunction

	// Offers one beat and waits until it is taken.
	task automatic offer(in_beat_t b, bit allow_gap);
		int gap;
		in_data <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		void'(wheel_apply(b));
		if (allow_gap && $urandom_range(99) < 9) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic in_beat_t random_beat();
		in_beat_t b;
		int pick;
		b.timer_id = 5'($urandom_range(POOL_SIZE - 1));
		b.periodic = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 75) b.command = CMD_TICK;
		else if (pick < 89) b.command = CMD_START;
		else if (pick < 98) b.command = CMD_STOP;
		else b.command = CMD_BAD;
		pick = $urandom_range(99);
		if (pick < 70) b.interval = $urandom_range(40);
		else if (pick < 90) b.interval = $urandom_range(600);
		else b.interval = $urandom;
		// Long periodic timers would never fire; keep most periodic ones short.
		if (b.periodic && pick >= 90 && $urandom_range(1)) b.interval = $urandom_range(8);
		return b;
	endfunction

	// Stimulus.
	initial begin
		row_t rows [$];
		int before_cnt;
		out_beat_t got;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		wheel_clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		rows = {rows, mk(CMD_TICK, 0, 0, 0)};
		rows = {rows, mk(CMD_START, 31, 0, 0)};
		rows = {rows, mk(CMD_TICK, 0, 0, 0, 1, 31, 1)};
		rows = {rows, mk(CMD_STOP, 5, 0, 0)};
		rows = {rows, mk(CMD_START, 0, 3, 1)};
		rows = {rows, mk(CMD_START, 1, 32'hffff_ffff, 0)};
		rows = {rows, mk(CMD_START, 2, 1000, 1)};
		rows = {rows, mk(CMD_START, 0, 2, 1)};
		rows = {rows, mk(CMD_START, 3, 300, 0)};
		rows = {rows, mk(CMD_STOP, 3, 0, 0)};
		rows = {rows, mk(CMD_START, 4, 0, 1)};
		rows = {rows, mk(CMD_TICK, 0, 0, 0, 1, 4, 2)};
		rows = {rows, mk(CMD_TICK, 31, 32'hffff_ffff, 1)};
		rows = {rows, mk(CMD_BAD, 31, 32'hffff_ffff, 1)};
		rows = {rows, mk(CMD_TICK, 0, 0, 0)};
		rows = {rows, mk(CMD_STOP, 4, 0, 0)};
		rows = {rows, mk(CMD_START, 7, 255, 0)};
		rows = {rows, mk(CMD_START, 8, 256, 0)};
		rows = {rows, mk(CMD_START, 9, 16384, 1)};
		rows = {rows, mk(CMD_START, 10, 32'h8000_0000, 0)};
		rows = {rows, mk(CMD_STOP, 1, 0, 0)};
		for (int k = 0; k < 4; k++) rows = {rows, mk(CMD_TICK, 0, 0, 0)};

		foreach (rows[i]) begin
			before_cnt = fired_q.size();
			offer(rows[i].beat, 1);
			if (rows[i].pinned) begin
				got = fired_q[$];
				if (fired_q.size() != before_cnt + 1 || got !== rows[i].want) begin
					$display("%0t: row %0d expected %p, predicted %p", $time, i,
						rows[i].want, got);
					errors++;
				end
			end
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 100) hold_req = ~hold_req;
			if (n == 200) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (fired_q.size() != 0) @(posedge clk);
			end
			offer(random_beat(), !(n >= 120 && n < 180));
		end
		in_valid <= 1'b0;

		while (fired_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Result side: checks each beat against the oldest prediction and drives stall.
	int  cyc = 0;
	int  hold_left = 0;
	int  taken = 0;
	bit  hold_seen = 0;
	out_beat_t want_r;

	initial out_stall = 1'b0;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > MAX_CYC) begin
			$display("TB_ERROR");
			$finish;
		end
		if (out_valid && !out_stall) begin
			taken <= taken + 1;
			if (fired_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
				errors++;
			end else begin
				want_r = fired_q.pop_front();
				if (out_data.fired_timer !== want_r.fired_timer) begin
					$display("%0t: fired_timer expected %0d actual %0d", $time,
						want_r.fired_timer, out_data.fired_timer);
					errors++;
				end
				if (out_data.fired_at !== want_r.fired_at) begin
					$display("%0t: fired_at expected %0d actual %0d", $time,
						want_r.fired_at, out_data.fired_at);
					errors++;
				end
				if (out_data.last_in_tick !== want_r.last_in_tick) begin
					$display("%0t: last_in_tick expected %0b actual %0b", $time,
						want_r.last_in_tick, out_data.last_in_tick);
					errors++;
				end
			end
		end
		// A long hold-off on request, a quiet stretch, otherwise random stalls.
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (taken >= 150 && taken < 250) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 9);
		end
	end

endmodule
